// ===== hw/rtl/line_pixel_stepper_macros.svh =====
// Assertion macros for the line pixel stepper RTL.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef LINE_PIXEL_STEPPER_MACROS_SVH
`define LINE_PIXEL_STEPPER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("line_pixel_stepper: implication check failed");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("line_pixel_stepper: next-cycle check failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/lps_pkg.sv =====
// Shared constants and types for the line pixel stepper.
// No dependencies; imported by every module of the block.
package lps_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int WIDTH_BITS     = 13;
	localparam int ADDR_BITS      = 26;
	localparam int COLOR_BITS     = 32;

	localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(1024);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// Status of the line walker toward the pipeline control.
	typedef struct packed {
		logic emit;    // the current transaction produces a pixel
		logic last;    // that pixel ends the line
		logic active;  // a line is in progress
	} walk_stat_t;

endpackage

// ===== hw/rtl/lps_walk.sv =====
// Line walker: endpoint setup on load, per-pixel error update, line state.
// Depends on lps_pkg.
module lps_walk import lps_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic                  opcode,
	input  logic [COORD_BITS-1:0] x0,
	input  logic [COORD_BITS-1:0] y0,
	input  logic [COORD_BITS-1:0] x1,
	input  logic [COORD_BITS-1:0] y1,
	input  logic [COLOR_BITS-1:0] color,
	output logic [COORD_BITS-1:0] px,
	output logic [COORD_BITS-1:0] py,
	output logic [COLOR_BITS-1:0] px_color,
	output walk_stat_t            stat
);

	localparam int ERR_W = COORD_BITS + 2;
	localparam int SUM_W = COORD_BITS + 3;

	logic                    active_q;
	logic [COORD_BITS-1:0]   major_pos_q, major_end_q, minor_pos_q, major_delta_q;
	logic signed [ERR_W-1:0] error_acc_q;
	logic [ERR_W-1:0]        error_step_q;
	logic                    steep_q, down_q;
	logic [COLOR_BITS-1:0]   color_q;

	logic [COORD_BITS-1:0]   dx, dy, a0, b0, a1, b1;
	logic [COORD_BITS-1:0]   ld_mpos, ld_mend, ld_minor, ld_minor_end, ld_mabs;
	logic                    ld_steep, ld_swap, is_load;

	logic [COORD_BITS-1:0]   cur_mpos, cur_mend, cur_minor, cur_delta;
	logic signed [ERR_W-1:0] cur_acc;
	logic [ERR_W-1:0]        cur_step;
	logic                    cur_steep, cur_down, last, do_minor;
	logic signed [SUM_W-1:0] acc_sum, acc_next;
	logic [COORD_BITS-1:0]   minor_next;

	// load setup: pick the major axis, order endpoints along it
	always_comb begin
		dx           = (x0 > x1) ? x0 - x1 : x1 - x0;
		dy           = (y0 > y1) ? y0 - y1 : y1 - y0;
		ld_steep     = dx < dy;
		a0           = ld_steep ? y0 : x0;
		b0           = ld_steep ? x0 : y0;
		a1           = ld_steep ? y1 : x1;
		b1           = ld_steep ? x1 : y1;
		ld_swap      = a0 > a1;
		ld_mpos      = ld_swap ? a1 : a0;
		ld_mend      = ld_swap ? a0 : a1;
		ld_minor     = ld_swap ? b1 : b0;
		ld_minor_end = ld_swap ? b0 : b1;
		ld_mabs      = ld_steep ? dx : dy;
	end

	assign is_load = (opcode == OP_LOAD);

	always_comb begin
		cur_mpos  = is_load ? ld_mpos : major_pos_q;
		cur_mend  = is_load ? ld_mend : major_end_q;
		cur_minor = is_load ? ld_minor : minor_pos_q;
		cur_delta = is_load ? (ld_mend - ld_mpos) : major_delta_q;
		cur_step  = is_load ? {1'b0, ld_mabs, 1'b0} : error_step_q;
		cur_acc   = is_load ? '0 : error_acc_q;
		cur_steep = is_load ? ld_steep : steep_q;
		cur_down  = is_load ? (ld_minor_end < ld_minor) : down_q;
		px_color  = is_load ? color : color_q;
	end

	// pixel out and error update; the sum can reach three major deltas
	always_comb begin
		px         = cur_steep ? cur_minor : cur_mpos;
		py         = cur_steep ? cur_mpos : cur_minor;
		last       = (cur_mpos == cur_mend);
		acc_sum    = {cur_acc[ERR_W-1], cur_acc} + {1'b0, cur_step};
		do_minor   = acc_sum > $signed({3'b000, cur_delta});
		acc_next   = do_minor ? acc_sum - $signed({2'b00, cur_delta, 1'b0}) : acc_sum;
		minor_next = cur_down ? cur_minor - 1'b1 : cur_minor + 1'b1;
	end

	assign stat.emit   = is_load || active_q;
	assign stat.last   = last;
	assign stat.active = active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (advance && stat.emit) begin
			active_q <= !last;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && stat.emit) begin
			major_end_q   <= cur_mend;
			major_delta_q <= cur_delta;
			error_step_q  <= cur_step;
			steep_q       <= cur_steep;
			down_q        <= cur_down;
			color_q       <= px_color;
			major_pos_q   <= last ? cur_mpos : cur_mpos + 1'b1;
			minor_pos_q   <= (!last && do_minor) ? minor_next : cur_minor;
			error_acc_q   <= last ? cur_acc : acc_next[ERR_W-1:0];
		end
	end

endmodule

// ===== hw/rtl/lps_addr.sv =====
// Output stage: byte address (row * width + column) * 4 and result register.
// Depends on lps_pkg.
module lps_addr import lps_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  load,
	input  logic [COORD_BITS-1:0] px,
	input  logic [COORD_BITS-1:0] py,
	input  logic [COLOR_BITS-1:0] color,
	input  logic                  last,
	input  logic [WIDTH_BITS-1:0] width,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [ADDR_BITS-1:0]  byte_address,
	output logic [COLOR_BITS-1:0] pixel_color,
	output logic                  last_pixel
);

	localparam int PROD_W = COORD_BITS + WIDTH_BITS + 1;
	localparam int SUM_W  = (PROD_W + 2 > ADDR_BITS) ? PROD_W + 2 : ADDR_BITS;

	logic [SUM_W-1:0] pix_index;

	assign pix_index = SUM_W'(py) * SUM_W'(width) + SUM_W'(px);

	always_ff @(posedge clk) begin
		if (load) begin
			pixel_x      <= px;
			pixel_y      <= py;
			byte_address <= ADDR_BITS'(pix_index << 2);
			pixel_color  <= color;
			last_pixel   <= last;
		end
	end

endmodule

// ===== hw/rtl/line_pixel_stepper.sv =====
// Line pixel stepper: integer line rasterizer, at most one pixel per transaction.
//
// Channels: in_* takes a load (opcode OP_LOAD: endpoints and color) or a step
// (OP_STEP); out_* returns pixel x/y, byte address, color and last_pixel.
// A load emits the first pixel of its line and replaces any line in progress;
// each step emits the next pixel. A step with no line in progress produces
// nothing. cfg_* writes image_width (pixels per row); cfg_ready is always high
// and width should only change while the block is idle.
// Throughput: one transaction per cycle unless out_ready back-pressure fills
// all stages. A result passes through the input register, the walker stage
// and the address/result register in turn. The walker updates its line state
// as each transaction advances; the row*width multiply sits in its own stage.
// Reset: asynchronous, active low; no line is active and image_width is 1024.
// Stalls: when out_ready is low the result register holds; the walker stage
// and input register keep filling, and in_ready drops only when all three
// stages are occupied.
// Depends on lps_pkg, lps_walk, lps_addr, line_pixel_stepper_macros.svh.
`include "line_pixel_stepper_macros.svh"

module line_pixel_stepper import lps_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [WIDTH_BITS-1:0] image_width,
	// input transactions
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	input  logic [COLOR_BITS-1:0] line_color,
	// result transactions
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [ADDR_BITS-1:0]  byte_address,
	output logic [COLOR_BITS-1:0] pixel_color,
	output logic                  last_pixel
);

	logic [WIDTH_BITS-1:0] width_q;

	// stage 1: input register
	logic                  valid_s1, opcode_s1;
	logic [COORD_BITS-1:0] x0_s1, y0_s1, x1_s1, y1_s1;
	logic [COLOR_BITS-1:0] color_s1;

	// stage 2: pixel from the walker
	logic                  valid_s2, last_s2;
	logic [COORD_BITS-1:0] x_s2, y_s2;
	logic [COLOR_BITS-1:0] color_s2;

	// stage 3: result register (payload lives in lps_addr)
	logic                  valid_s3;

	logic                  ready_s1, ready_s2, advance;
	logic [COORD_BITS-1:0] walk_x, walk_y;
	logic [COLOR_BITS-1:0] walk_color;
	walk_stat_t            stat;

	// a stage may load when it is empty or its contents move on
	assign ready_s2  = !valid_s3 || out_ready;
	assign ready_s1  = !valid_s2 || ready_s2;
	assign in_ready  = !valid_s1 || ready_s1;
	assign advance   = valid_s1 && ready_s1;
	assign out_valid = valid_s3;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
		end else if (cfg_valid) begin
			width_q <= image_width;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s1) begin
				valid_s2 <= advance && stat.emit;
			end
			if (ready_s2) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			x0_s1     <= start_x;
			y0_s1     <= start_y;
			x1_s1     <= end_x;
			y1_s1     <= end_y;
			color_s1  <= line_color;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && stat.emit) begin
			x_s2     <= walk_x;
			y_s2     <= walk_y;
			color_s2 <= walk_color;
			last_s2  <= stat.last;
		end
	end

	lps_walk #(
		.COORD_BITS(COORD_BITS)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.opcode   (opcode_s1),
		.x0       (x0_s1),
		.y0       (y0_s1),
		.x1       (x1_s1),
		.y1       (y1_s1),
		.color    (color_s1),
		.px       (walk_x),
		.py       (walk_y),
		.px_color (walk_color),
		.stat     (stat)
	);

	lps_addr #(
		.COORD_BITS(COORD_BITS)
	) u_addr (
		.clk          (clk),
		.load         (valid_s2 && ready_s2),
		.px           (x_s2),
		.py           (y_s2),
		.color        (color_s2),
		.last         (last_s2),
		.width        (width_q),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.byte_address (byte_address),
		.pixel_color  (pixel_color),
		.last_pixel   (last_pixel)
	);

	// a step with no line in progress must not create a pixel
	`ASSERT_NEXT(a_idle_step_silent, clk, arst_n, advance && opcode_s1 == OP_STEP && !stat.active, !valid_s2)
	// every load produces a pixel
	`ASSERT_IMPLIES(a_load_emits, clk, arst_n, advance && opcode_s1 == OP_LOAD, stat.emit)
	// the final pixel ends the line
	`ASSERT_NEXT(a_last_ends_line, clk, arst_n, advance && stat.emit && stat.last, !stat.active)
	// a blocked walker stage keeps its pixel
	`ASSERT_NEXT(a_s2_holds, clk, arst_n, valid_s2 && !ready_s1, valid_s2 && $stable(x_s2) && $stable(y_s2))

endmodule

// ===== dv/line_pixel_stepper_tb.sv =====
// Self-checking testbench for line_pixel_stepper: line loads, pixel steps, row width.
// Depends on lps_pkg and the line_pixel_stepper RTL; nothing else is read.
// A cycle-free line walker predicts every pixel; results are checked in order.
module line_pixel_stepper_tb;
	import lps_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam logic [CB-1:0] COORD_MAX = '1;

	// One expected pixel, laid out like the result ports.
	typedef struct packed {
		logic [CB-1:0]         x;
		logic [CB-1:0]         y;
		logic [ADDR_BITS-1:0]  addr;
		logic [COLOR_BITS-1:0] color;
		logic                  is_last;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// DUT inputs, all known from time zero
	logic                  cfg_valid = 1'b0;
	logic [WIDTH_BITS-1:0] image_width = '0;
	logic                  in_valid = 1'b0;
	logic                  opcode = OP_STEP;
	logic [CB-1:0]         start_x = '0;
	logic [CB-1:0]         start_y = '0;
	logic [CB-1:0]         end_x = '0;
	logic [CB-1:0]         end_y = '0;
	logic [COLOR_BITS-1:0] line_color = '0;
	logic                  out_ready = 1'b0;

	// DUT outputs
	logic                  cfg_ready;
	logic                  in_ready;
	logic                  out_valid;
	logic [CB-1:0]         pixel_x;
	logic [CB-1:0]         pixel_y;
	logic [ADDR_BITS-1:0]  byte_address;
	logic [COLOR_BITS-1:0] pixel_color;
	logic                  last_pixel;

	// Line walker state mirrored by the predictor
	logic                  line_active = 1'b0;
	logic [CB-1:0]         major_at = '0;
	logic [CB-1:0]         major_stop = '0;
	logic [CB-1:0]         minor_at = '0;
	int                    err_acc = 0;
	int                    err_inc = 0;
	int                    major_span = 0;
	logic                  line_steep = 1'b0;
	logic                  minor_down = 1'b0;
	logic [COLOR_BITS-1:0] held_rgba = '0;
	logic [WIDTH_BITS-1:0] row_pixels = WIDTH_RESET;

	pixel_t pending_pixels[$];   // predicted pixels not yet seen on the output
	int pixels_predicted = 0;
	int mismatches = 0;

	// Traffic shaping knobs, percent of cycles
	int send_idle_pct = 0;
	int ready_stall_pct = 0;
	int hold_request = 0;        // long output hold, in cycles
	int hold_left = 0;

	line_pixel_stepper u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.image_width (image_width),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.line_color  (line_color),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.byte_address(byte_address),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel)
	);

	always #6 clk = ~clk;

	// Hard stop; far beyond the slowest legal run.
	initial begin
		#3000000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int coord_span(logic [CB-1:0] a, logic [CB-1:0] b);
		return (a > b) ? int'(a - b) : int'(b - a);
	endfunction

	// Emit the walker's pixel, then move one step on the major axis unless that pixel ends the line.
	function automatic void walk_one_pixel();
		pixel_t pix;
		logic [63:0] prod;
		int acc;
		pix.x = line_steep ? minor_at : major_at;
		pix.y = line_steep ? major_at : minor_at;
		// row * width + column, in bytes; wraps to the address width
		prod = (64'(pix.y) * 64'(row_pixels) + 64'(pix.x)) << 2;
		pix.addr = prod[ADDR_BITS-1:0];
		pix.color = held_rgba;
		pix.is_last = (major_at == major_stop);
		pending_pixels.push_back(pix);
		pixels_predicted++;
		if (pix.is_last) begin
			line_active = 1'b0;
		end else begin
			acc = err_acc + err_inc;
			if (acc > major_span) begin
				minor_at = minor_down ? minor_at - 1'b1 : minor_at + 1'b1;
				acc -= 2 * major_span;
			end
			err_acc = acc;
			major_at = major_at + 1'b1;
		end
	endfunction

	// Set up a new line (replacing any in progress) and emit its first pixel.
	function automatic void load_line(logic [CB-1:0] x0, logic [CB-1:0] y0,
			logic [CB-1:0] x1, logic [CB-1:0] y1, logic [COLOR_BITS-1:0] rgba);
		logic [CB-1:0] a0, b0, a1, b1, t;
		logic steep;
		// equal deltas stay x-major
		steep = coord_span(x0, x1) < coord_span(y0, y1);
		if (steep) begin
			a0 = y0; b0 = x0; a1 = y1; b1 = x1;
		end else begin
			a0 = x0; b0 = y0; a1 = x1; b1 = y1;
		end
		// walk with the major coordinate rising
		if (a0 > a1) begin
			t = a0; a0 = a1; a1 = t;
			t = b0; b0 = b1; b1 = t;
		end
		line_steep = steep;
		major_at = a0;
		major_stop = a1;
		minor_at = b0;
		major_span = int'(a1 - a0);
		minor_down = (b1 < b0);
		err_inc = 2 * coord_span(b0, b1);
		err_acc = 0;
		held_rgba = rgba;
		line_active = 1'b1;
		walk_one_pixel();
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, exp_val));
	endtask

	// Monitor: check the output transaction first, then predict from the input
	// transaction of the same edge. An input can't show up on the output at the
	// edge it is taken, so this order is fixed and race free.
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_pixels.size() == 0) begin
					report_mismatch($sformatf("pixel (%0d,%0d) with none expected",
						pixel_x, pixel_y));
				end else begin
					want = pending_pixels.pop_front();
					check_field("pixel_x", 32'(pixel_x), 32'(want.x));
					check_field("pixel_y", 32'(pixel_y), 32'(want.y));
					check_field("byte_address", 32'(byte_address), 32'(want.addr));
					check_field("pixel_color", pixel_color, want.color);
					check_field("last_pixel", 32'(last_pixel), 32'(want.is_last));
				end
			end
			if (cfg_valid && cfg_ready)
				row_pixels = image_width;
			if (in_valid && in_ready) begin
				if (opcode == OP_LOAD)
					load_line(start_x, start_y, end_x, end_y, line_color);
				else if (line_active)
					walk_one_pixel();
				// a step with no line in progress gives nothing
			end
		end
	end

	// Receiver: random stalls plus an optional long hold counted here.
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end else if (hold_left != 0) begin
			hold_left--;
		end
		out_ready <= (hold_left == 0) && ($urandom_range(99) >= ready_stall_pct);
	end

	// Offer one input transaction and return at the edge that takes it.
	// Valid is left high afterward; the next call either replaces the payload
	// or drops valid for an idle gap, so each negedge sees one assignment.
	task automatic send_item(input logic op, input logic [CB-1:0] x0,
			input logic [CB-1:0] y0, input logic [CB-1:0] x1, input logic [CB-1:0] y1,
			input logic [COLOR_BITS-1:0] rgba);
		@(negedge clk);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		opcode <= op;
		start_x <= x0;
		start_y <= y0;
		end_x <= x1;
		end_y <= y1;
		line_color <= rgba;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_load(input logic [CB-1:0] x0, input logic [CB-1:0] y0,
			input logic [CB-1:0] x1, input logic [CB-1:0] y1,
			input logic [COLOR_BITS-1:0] rgba);
		send_item(OP_LOAD, x0, y0, x1, y1, rgba);
	endtask

	// Step payload is ignored by the block; randomize it anyway.
	task automatic send_step();
		send_item(OP_STEP, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
			$urandom);
	endtask

	// Stop offering, wait for every predicted pixel, then let the pipe empty
	// of idle steps.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Width changes only with the block idle.
	task automatic write_width(input logic [WIDTH_BITS-1:0] w);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		image_width <= w;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Endpoint offset by d, reflected back if it would leave the coordinate range.
	function automatic logic [CB-1:0] offset_coord(logic [CB-1:0] base, int d);
		int v;
		v = int'(base) + d;
		if (v < 0 || v > int'(COORD_MAX))
			v = int'(base) - d;
		return CB'(v);
	endfunction

	// One well-formed line: load, then steps to the end, sometimes a few past
	// the end (idle steps), sometimes cut short so the next load replaces it.
	task automatic draw_random_line();
		logic [CB-1:0] x0, y0, x1, y1;
		int dx, dy, len, steps, kind;
		x0 = CB'($urandom);
		y0 = CB'($urandom);
		kind = $urandom_range(99);
		if (kind < 12) begin
			x1 = CB'($urandom);
			y1 = CB'($urandom);
		end else begin
			dx = int'($urandom_range(30)) - 15;
			dy = int'($urandom_range(30)) - 15;
			if (kind < 22) begin
				dy = $urandom_range(1) ? dx : -dx;
			end else if (kind < 30) begin
				dx = 0;
				dy = 0;
			end
			x1 = offset_coord(x0, dx);
			y1 = offset_coord(y0, dy);
		end
		len = coord_span(x0, x1);
		if (coord_span(y0, y1) > len)
			len = coord_span(y0, y1);
		send_load(x0, y0, x1, y1, $urandom);
		if (kind < 12 || $urandom_range(4) == 0)
			steps = $urandom_range((len < 24) ? len : 24, 0);
		else
			steps = len + (($urandom_range(5) == 0) ? $urandom_range(3, 1) : 0);
		repeat (steps) send_step();
	endtask

	// ---------------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------------

	// Directed lines at the reset width: idle steps, single points at both
	// corners, shallow, diagonal, steep reversed, replacement while active.
	task automatic test_directed_lines();
		send_step();                                       // nothing in progress
		send_load('0, '0, '0, '0, '0);                     // single point, origin
		send_load(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, '1);
		send_step();                                       // line already finished
		send_load(12'd10, 12'd20, 12'd14, 12'd22, 32'h11223344);
		repeat (4) send_step();
		send_load(12'd5, 12'd8, 12'd8, 12'd5, 32'hA5A5_5A5A);   // equal deltas, y down
		repeat (3) send_step();
		send_load(12'd30, 12'd40, 12'd28, 12'd35, 32'h0F0F_F0F0); // steep, reversed
		repeat (2) send_step();
		send_load(12'd100, 12'd7, 12'd96, 12'd7, 32'hDEAD_BEEF);  // replaces the above
		repeat (5) send_step();                            // last one is idle
		drain_results();
	endtask

	// Width extremes, including zero and above range; corner pixel stresses
	// the address wrap.
	task automatic test_width_extremes();
		logic [WIDTH_BITS-1:0] widths[4];
		widths = '{13'd0, 13'd1, 13'd4096, 13'd8191};
		foreach (widths[i]) begin
			write_width(widths[i]);
			send_load(COORD_MAX, COORD_MAX, COORD_MAX - 12'd1, COORD_MAX, $urandom);
			send_step();
		end
	endtask

	// Hold the output for a long stretch while steps keep coming, so the
	// pipeline fills and in_ready drops.
	task automatic test_output_backpressure();
		write_width(13'd640);
		send_idle_pct = 0;
		ready_stall_pct = 0;
		send_load(12'd0, 12'd0, 12'd200, 12'd77, $urandom);
		hold_request = 120;
		repeat (40) send_step();
		drain_results();
	endtask

	// Mostly well-formed lines with random content, some noise transactions.
	task automatic test_random_lines(input int idle_pct, input int stall_pct,
			input int target);
		int goal;
		write_width(WIDTH_BITS'($urandom_range(4096, 1)));
		send_idle_pct = idle_pct;
		ready_stall_pct = stall_pct;
		goal = pixels_predicted + target;
		while (pixels_predicted < goal) begin
			if ($urandom_range(99) < 8)
				send_item(1'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
					CB'($urandom), $urandom);
			else
				draw_random_line();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_lines();
		test_width_extremes();
		test_output_backpressure();
		test_random_lines(0, 0, 250);
		test_random_lines(57, 0, 250);
		test_random_lines(0, 57, 250);
		test_random_lines(16, 16, 250);

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
